/* sv/dsse_pkg.sv */
// ----------------------------------------------------------------------------
// dsse_pkg
// Shared widths, seven-segment font and pipeline types for the dual score
// seven-segment encoder.
// ----------------------------------------------------------------------------
package dsse_pkg;

	localparam int DIGITS_DEFAULT = 4;
	localparam int VALUE_W        = 16;
	localparam int BCD_DIGITS     = 5;
	localparam int BCD_W          = 4 * BCD_DIGITS;
	localparam int SEG_W          = 8;
	localparam int S_TDATA_W      = 40;
	localparam int DD_STEPS       = 8;

	localparam logic [SEG_W-1:0] SEG_BLANK      = 8'hFF;
	localparam logic [SEG_W-1:0] SEG_POINT_MASK = 8'h7F;

	// double dabble state: bcd digits above the remaining binary bits
	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [VALUE_W-1:0] bin;
	} dsse_dd_t;

	typedef struct packed {
		dsse_dd_t   first;
		dsse_dd_t   second;
		logic       first_blank;
		logic       second_blank;
		logic       point_enable;
		logic [2:0] point_position;
	} dsse_work_t;

	// active-low common-anode font, bit 7 is the point
	function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
		logic [SEG_W-1:0] pat;
		case (digit)
			4'd0:    pat = 8'hC0;
			4'd1:    pat = 8'hF9;
			4'd2:    pat = 8'hA4;
			4'd3:    pat = 8'hB0;
			4'd4:    pat = 8'h99;
			4'd5:    pat = 8'h92;
			4'd6:    pat = 8'h82;
			4'd7:    pat = 8'hF8;
			4'd8:    pat = 8'h80;
			4'd9:    pat = 8'h90;
			default: pat = SEG_BLANK;
		endcase
		return pat;
	endfunction

endpackage

/* sv/dsse_convert.sv */
// ----------------------------------------------------------------------------
// dsse_convert
// Two-stage binary to bcd conversion of both scores, eight double dabble
// steps per stage, with valid/ready flow control between stages.
// ----------------------------------------------------------------------------
module dsse_convert (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dsse_pkg::dsse_work_t in_work,
	output logic                out_valid,
	input  logic                out_ready,
	output dsse_pkg::dsse_work_t out_work
);

	function automatic dsse_pkg::dsse_dd_t dd_step(input dsse_pkg::dsse_dd_t x);
		logic [dsse_pkg::BCD_W-1:0] b;
		dsse_pkg::dsse_dd_t         y;
		b = x.bcd;
		for (int d = 0; d < dsse_pkg::BCD_DIGITS; d++) begin
			if (b[4*d +: 4] >= 4'd5) begin
				b[4*d +: 4] = b[4*d +: 4] + 4'd3;
			end
		end
		y.bcd = {b[dsse_pkg::BCD_W-2:0], x.bin[dsse_pkg::VALUE_W-1]};
		y.bin = {x.bin[dsse_pkg::VALUE_W-2:0], 1'b0};
		return y;
	endfunction

	function automatic dsse_pkg::dsse_work_t dd_half(input dsse_pkg::dsse_work_t w);
		dsse_pkg::dsse_work_t r;
		r = w;
		for (int s = 0; s < dsse_pkg::DD_STEPS; s++) begin
			r.first  = dd_step(r.first);
			r.second = dd_step(r.second);
		end
		return r;
	endfunction

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 ready_s1;
	logic                 ready_s2;
	dsse_pkg::dsse_work_t work_s1;
	dsse_pkg::dsse_work_t work_s2;

	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s2;
	assign out_work  = work_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			work_s1 <= dd_half(in_work);
		end
		if (ready_s2 && valid_s1) begin
			work_s2 <= dd_half(work_s1);
		end
	end

endmodule

/* sv/dsse_encode.sv */
// ----------------------------------------------------------------------------
// dsse_encode
// Font lookup, blanking and decimal point for all digits of a frame, one
// register stage.
// ----------------------------------------------------------------------------
module dsse_encode #(
	parameter int DIGITS = dsse_pkg::DIGITS_DEFAULT
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  dsse_pkg::dsse_work_t                      in_work,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [2*DIGITS-1:0][dsse_pkg::SEG_W-1:0]  out_frame
);

	logic                                     valid_s3;
	logic                                     ready_s3;
	logic [2*DIGITS-1:0][dsse_pkg::SEG_W-1:0] frame_s3;
	logic [2*DIGITS-1:0][dsse_pkg::SEG_W-1:0] frame_d;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			logic [dsse_pkg::SEG_W-1:0] mask;
			mask = (in_work.point_enable && in_work.point_position == 3'(i)) ?
				dsse_pkg::SEG_POINT_MASK : dsse_pkg::SEG_BLANK;
			frame_d[i] = in_work.second_blank ? dsse_pkg::SEG_BLANK :
				(dsse_pkg::seg_font(in_work.second.bcd[4*i +: 4]) & mask);
			frame_d[DIGITS + i] = in_work.first_blank ? dsse_pkg::SEG_BLANK :
				(dsse_pkg::seg_font(in_work.first.bcd[4*i +: 4]) & mask);
		end
	end

	assign ready_s3  = !valid_s3 || out_ready;
	assign in_ready  = ready_s3;
	assign out_valid = valid_s3;
	assign out_frame = frame_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			frame_s3 <= frame_d;
		end
	end

endmodule

/* sv/dsse_serialize.sv */
// ----------------------------------------------------------------------------
// dsse_serialize
// Output register that shifts a frame out one byte per item, with display
// select and last flag, taking the next frame as the last byte leaves.
// ----------------------------------------------------------------------------
module dsse_serialize #(
	parameter int DIGITS = dsse_pkg::DIGITS_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [2*DIGITS-1:0][dsse_pkg::SEG_W-1:0] in_frame,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [dsse_pkg::SEG_W-1:0]               out_pattern,
	output logic                                     out_select,
	output logic                                     out_last
);

	localparam int NBYTES = 2 * DIGITS;
	localparam int CNT_W  = (NBYTES > 1) ? $clog2(NBYTES) : 1;

	logic                                     valid_q;
	logic [CNT_W-1:0]                         count_q;
	logic [NBYTES-1:0][dsse_pkg::SEG_W-1:0]   frame_q;
	logic                                     last;
	logic                                     load;

	assign last        = count_q == CNT_W'(NBYTES - 1);
	assign in_ready    = !valid_q || (out_ready && last);
	assign load        = in_ready && in_valid;
	assign out_valid   = valid_q;
	assign out_pattern = frame_q[0];
	assign out_select  = count_q >= CNT_W'(DIGITS);
	assign out_last    = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			count_q <= '0;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
				count_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= in_frame;
		end else if (valid_q && out_ready) begin
			for (int i = 0; i < NBYTES - 1; i++) begin
				frame_q[i] <= frame_q[i+1];
			end
		end
	end

endmodule

/* sv/dual_score_seven_segment_encoder.sv */
// ----------------------------------------------------------------------------
// dual_score_seven_segment_encoder
// Turns two scores into a frame of active-low seven-segment bytes for a
// daisy-chained display.
//
// The slave channel takes one item per update: both scores, their blank
// flags and the decimal point setting. The master channel gives 2*DIGITS
// items per update, one byte each: the second score's digits units first,
// then the first score's digits units first. tuser marks first-score bytes
// and tlast flags the final byte of the frame, when the chain is latched.
// The item passes two bcd conversion stages and one font stage before the
// output register, which puts its first byte on m_tdata. A frame leaves at
// one byte per cycle while m_tready is held high; the output register is
// the limit. The next update is taken as the last byte of the current
// frame leaves, and up to three more wait in the stages behind it. When
// the receiver stalls, the current byte holds and the stages fill, then
// s_tready drops. Reset empties every stage and drops m_tvalid; no frame
// is pending afterwards.
// ----------------------------------------------------------------------------
module dual_score_seven_segment_encoder #(
	parameter int DIGITS = dsse_pkg::DIGITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// first_value[15:0], first_blank, second_value, second_blank,
	// point_enable, point_position[2:0], zero pad
	input  logic [dsse_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// segment_pattern[7:0]
	output logic [dsse_pkg::SEG_W-1:0]        m_tdata,
	// display_select
	output logic                              m_tuser,
	output logic                              m_tlast
);

	dsse_pkg::dsse_work_t                     in_work;
	dsse_pkg::dsse_work_t                     conv_work;
	logic                                     conv_valid;
	logic                                     conv_ready;
	logic                                     enc_valid;
	logic                                     enc_ready;
	logic [2*DIGITS-1:0][dsse_pkg::SEG_W-1:0] enc_frame;

	always_comb begin
		in_work.first.bcd      = '0;
		in_work.first.bin      = s_tdata[15:0];
		in_work.first_blank    = s_tdata[16];
		in_work.second.bcd     = '0;
		in_work.second.bin     = s_tdata[32:17];
		in_work.second_blank   = s_tdata[33];
		in_work.point_enable   = s_tdata[34];
		in_work.point_position = s_tdata[37:35];
	end

	dsse_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_work   (in_work),
		.out_valid (conv_valid),
		.out_ready (conv_ready),
		.out_work  (conv_work)
	);

	dsse_encode #(
		.DIGITS (DIGITS)
	) u_encode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (conv_valid),
		.in_ready  (conv_ready),
		.in_work   (conv_work),
		.out_valid (enc_valid),
		.out_ready (enc_ready),
		.out_frame (enc_frame)
	);

	dsse_serialize #(
		.DIGITS (DIGITS)
	) u_serialize (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (enc_valid),
		.in_ready    (enc_ready),
		.in_frame    (enc_frame),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_pattern (m_tdata),
		.out_select  (m_tuser),
		.out_last    (m_tlast)
	);

endmodule
